### hw/rtl/line_follower_mode_controller_unit_assert.svh
// Assertion macros shared by the line follower mode controller RTL.
`ifndef LINE_FOLLOWER_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define LINE_FOLLOWER_MODE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, idle during reset.
`define LFMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, idle during reset.
`define LFMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lfmc_pkg.sv
// Shared types and constants of the line follower mode controller.
package lfmc_pkg;

  // Configuration register width and indexes
  localparam int unsigned CFG_W = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_WIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_TMO  = 3'd4;

  localparam logic [CFG_W-1:0] CFG_HOLD_RST      = 12'd600;
  localparam logic [CFG_W-1:0] CFG_LONG_HOLD_RST = 12'd3000;
  localparam logic [CFG_W-1:0] CFG_DBL_WIN_RST   = 12'd400;
  localparam logic [CFG_W-1:0] CFG_CENTER_RST    = 12'd150;
  localparam logic [CFG_W-1:0] CFG_TURN_TMO_RST  = 12'd2000;

  // Gesture codes
  localparam logic [2:0] GES_NONE   = 3'd0;
  localparam logic [2:0] GES_SINGLE = 3'd1;
  localparam logic [2:0] GES_DOUBLE = 3'd2;
  localparam logic [2:0] GES_HOLD   = 3'd3;
  localparam logic [2:0] GES_LONG   = 3'd4;

  // Mode codes
  localparam logic [2:0] MODE_STOP = 3'd0;
  localparam logic [2:0] MODE_RUN  = 3'd1;
  localparam logic [2:0] MODE_TUNE = 3'd2;
  localparam logic [2:0] MODE_FWD  = 3'd3;
  localparam logic [2:0] MODE_TURN = 3'd4;

  // Speed table: normal, gentle turn, hard turn, lost line
  localparam logic [1:0] SPD_NORMAL = 2'd0;
  localparam logic [1:0] SPD_GENTLE = 2'd1;
  localparam logic [1:0] SPD_HARD   = 2'd2;
  localparam logic [1:0] SPD_LOST   = 2'd3;
  localparam logic [7:0] SPD_RST [4] = '{8'd255, 8'd150, 8'd100, 8'd200};
  localparam logic [7:0] SPD_MIN [4] = '{8'd50, 8'd0, 8'd0, 8'd50};
  localparam logic [7:0] SPD_MAX [4] = '{8'd255, 8'd255, 8'd200, 8'd255};
  localparam logic signed [9:0] SPEED_STEP = 10'sd10;

  localparam logic [4:0] SENS_ALL = 5'h1F;

  // Depth of the queue between classifier and mode machine
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] long_hold_ticks;
    logic [CFG_W-1:0] double_tap_window;
    logic [CFG_W-1:0] center_ticks;
    logic [CFG_W-1:0] turn_timeout_ticks;
  } cfg_t;

  // Classified tick passed from front to back
  typedef struct packed {
    logic [4:0] sensors;
    logic [2:0] gesture;
  } item_t;

  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [2:0] mode;
    logic [2:0] gesture;
    logic [1:0] selected_speed;
    logic       tune_upward;
    logic       save_pulse;
    logic [7:0] normal_speed;
    logic [7:0] gentle_turn_speed;
    logic [7:0] hard_turn_speed;
    logic [7:0] lost_line_speed;
  } res_t;

endpackage

### hw/rtl/lfmc_front.sv
// Gesture classifier: turns button timing into tap, double tap, hold and long hold events.
module lfmc_front import lfmc_pkg::*; #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  sensors_i,
  input  logic        button_i,
  output logic        push_o,
  output item_t       item_o,
  input  logic        q_ready_i
);

  localparam int unsigned CW = (TIMER_BITS + 1 > CFG_W) ? TIMER_BITS + 1 : CFG_W;
  localparam logic [TIMER_BITS-1:0] AGE_MAX = {TIMER_BITS{1'b1}};

  logic                  was_down_q, was_down_d;
  logic [TIMER_BITS-1:0] press_q, press_d;
  logic [TIMER_BITS-1:0] rel_q, rel_d;
  logic [1:0]            taps_q, taps_d;
  logic                  pend_q, pend_d;
  logic                  press_clr, rel_clr, accept;
  logic [CW-1:0]         held;
  logic [2:0]            ev;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign push_o     = accept;
  assign held       = CW'(press_q) + CW'(1'b1);

  // Press/release edge handling and tap decision
  always_comb begin
    taps_d    = taps_q;
    pend_d    = pend_q;
    ev        = GES_NONE;
    press_clr = 1'b0;
    rel_clr   = 1'b0;
    if (!was_down_q && button_i) begin
      press_clr = 1'b1;
    end else if (was_down_q && !button_i) begin
      if (held >= CW'(cfg_i.long_hold_ticks)) begin
        ev     = GES_LONG;
        taps_d = 2'd0;
        pend_d = 1'b0;
      end else if (held >= CW'(cfg_i.hold_ticks)) begin
        ev     = GES_HOLD;
        taps_d = 2'd0;
        pend_d = 1'b0;
      end else begin
        if (taps_q != 2'd3) taps_d = taps_q + 2'd1;
        rel_clr = 1'b1;
        pend_d  = 1'b1;
      end
    end
    // a tap is decided once the window has passed with no new release
    if (pend_d && !rel_clr && (CW'(rel_q) >= CW'(cfg_i.double_tap_window))) begin
      ev     = (taps_d >= 2'd2) ? GES_DOUBLE : GES_SINGLE;
      taps_d = 2'd0;
      pend_d = 1'b0;
    end
    was_down_d = button_i;
    press_d = press_clr ? '0 : ((press_q != AGE_MAX) ? press_q + 1'b1 : press_q);
    rel_d   = rel_clr   ? '0 : ((rel_q   != AGE_MAX) ? rel_q   + 1'b1 : rel_q);
  end

  assign item_o.sensors = sensors_i;
  assign item_o.gesture = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q <= 1'b0;
      press_q    <= '0;
      rel_q      <= '0;
      taps_q     <= 2'd0;
      pend_q     <= 1'b0;
    end else if (accept) begin
      was_down_q <= was_down_d;
      press_q    <= press_d;
      rel_q      <= rel_d;
      taps_q     <= taps_d;
      pend_q     <= pend_d;
    end
  end

endmodule

### hw/rtl/lfmc_queue.sv
// Two-entry queue decoupling the gesture classifier from the mode machine.
module lfmc_queue import lfmc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  ready_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t pop_data_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QDEPTH + 1);

  item_t           mem_q [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign ready_o    = (cnt_q != CNTW'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/lfmc_back.sv
// Mode machine, speed tuning and wheel drive selection with output register.
`include "line_follower_mode_controller_unit_assert.svh"
module lfmc_back import lfmc_pkg::*; #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_data_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  localparam int unsigned CW = (TIMER_BITS + 1 > CFG_W) ? TIMER_BITS + 1 : CFG_W;
  localparam logic [TIMER_BITS-1:0] AGE_MAX = {TIMER_BITS{1'b1}};

  logic [2:0]            mode_q, mode_cur, mode_n;
  logic [7:0]            spd_q [4];
  logic [7:0]            spd_n [4];
  logic [1:0]            sel_q, sel_n;
  logic                  up_q, up_n;
  logic [TIMER_BITS-1:0] iage_q, iage_d;
  logic                  inter_clr, save;
  logic [7:0]            left, right, cur;
  logic signed [9:0]     stepped;
  logic [CW-1:0]         elapsed;
  logic [4:0]            s;
  logic [2:0]            ev;
  logic                  pop, out_valid_q;
  res_t                  res_q, res_d;

  assign pop         = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign s           = q_data_i.sensors;
  assign ev          = q_data_i.gesture;
  assign elapsed     = CW'(iage_q) + CW'(1'b1);

  // Tuning step of the selected speed
  assign cur     = spd_q[sel_q];
  assign stepped = up_q ? $signed({2'b00, cur}) + SPEED_STEP
                        : $signed({2'b00, cur}) - SPEED_STEP;

  // Event handling, then drive selection in the resulting mode
  always_comb begin
    mode_cur  = (mode_q > MODE_TURN) ? MODE_STOP : mode_q;
    mode_n    = mode_cur;
    sel_n     = sel_q;
    up_n      = up_q;
    spd_n     = spd_q;
    save      = 1'b0;
    inter_clr = 1'b0;
    left      = 8'd0;
    right     = 8'd0;
    case (mode_cur)
      MODE_STOP: begin
        if (ev == GES_SINGLE) begin
          mode_n = MODE_RUN;
        end else if (ev == GES_HOLD) begin
          mode_n = MODE_TUNE;
          sel_n  = SPD_NORMAL;
          up_n   = 1'b1;
        end
      end
      MODE_TUNE: begin
        case (ev)
          GES_SINGLE: begin
            if (stepped < $signed({2'b00, SPD_MIN[sel_q]})) spd_n[sel_q] = SPD_MIN[sel_q];
            else if (stepped > $signed({2'b00, SPD_MAX[sel_q]})) spd_n[sel_q] = SPD_MAX[sel_q];
            else spd_n[sel_q] = stepped[7:0];
          end
          GES_DOUBLE: up_n = !up_q;
          GES_HOLD:   sel_n = sel_q + 2'd1;
          GES_LONG: begin
            save   = 1'b1;
            mode_n = MODE_STOP;
          end
          default: ;
        endcase
      end
      default: begin
        if (ev == GES_SINGLE) begin
          mode_n = MODE_STOP;
        end else if (ev == GES_HOLD) begin
          mode_n = MODE_TUNE;
          sel_n  = SPD_NORMAL;
          up_n   = 1'b1;
        end
      end
    endcase

    case (mode_n)
      MODE_RUN: begin
        if (s == SENS_ALL) begin
          mode_n    = MODE_FWD;
          inter_clr = 1'b1;
          left      = spd_n[SPD_NORMAL];
          right     = spd_n[SPD_NORMAL];
        end else if (s == 5'd0) begin
          left  = spd_n[SPD_LOST];
          right = spd_n[SPD_LOST];
        end else if (s[4]) begin
          left  = spd_n[SPD_NORMAL];
          right = spd_n[SPD_HARD];
        end else if (s[3]) begin
          left  = spd_n[SPD_NORMAL];
          right = spd_n[SPD_GENTLE];
        end else if (s[2] && !s[1]) begin
          left  = spd_n[SPD_NORMAL];
          right = spd_n[SPD_NORMAL];
        end else if (s[1] && !s[0]) begin
          left  = spd_n[SPD_GENTLE];
          right = spd_n[SPD_NORMAL];
        end else if (s[0]) begin
          left  = spd_n[SPD_HARD];
          right = spd_n[SPD_NORMAL];
        end else begin
          left  = spd_n[SPD_NORMAL];
          right = spd_n[SPD_NORMAL];
        end
      end
      MODE_FWD: begin
        left  = spd_n[SPD_NORMAL];
        right = spd_n[SPD_NORMAL];
        if (elapsed >= CW'(cfg_i.center_ticks)) begin
          mode_n    = MODE_TURN;
          inter_clr = 1'b1;
        end
      end
      MODE_TURN: begin
        left = spd_n[SPD_NORMAL];
        if (s[2] || (elapsed >= CW'(cfg_i.turn_timeout_ticks))) mode_n = MODE_RUN;
      end
      default: ;
    endcase

    iage_d = inter_clr ? '0 : ((iage_q != AGE_MAX) ? iage_q + 1'b1 : iage_q);

    res_d.left_speed        = left;
    res_d.right_speed       = right;
    res_d.mode              = mode_n;
    res_d.gesture           = ev;
    res_d.selected_speed    = sel_n;
    res_d.tune_upward       = up_n;
    res_d.save_pulse        = save;
    res_d.normal_speed      = spd_n[SPD_NORMAL];
    res_d.gentle_turn_speed = spd_n[SPD_GENTLE];
    res_d.hard_turn_speed   = spd_n[SPD_HARD];
    res_d.lost_line_speed   = spd_n[SPD_LOST];
  end

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STOP;
      spd_q[0]    <= SPD_RST[0];
      spd_q[1]    <= SPD_RST[1];
      spd_q[2]    <= SPD_RST[2];
      spd_q[3]    <= SPD_RST[3];
      sel_q       <= SPD_NORMAL;
      up_q        <= 1'b1;
      iage_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mode_q <= mode_n;
        spd_q  <= spd_n;
        sel_q  <= sel_n;
        up_q   <= up_n;
        iage_q <= iage_d;
      end
      if (pop) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (pop) res_q <= res_d;
  end

  `LFMC_ASSERT_IMP(a_save_on_long, out_valid_q && res_q.save_pulse, res_q.gesture == GES_LONG, "save pulse without long hold")
  `LFMC_ASSERT_IMP(a_idle_wheels, out_valid_q && (res_q.mode == MODE_STOP || res_q.mode == MODE_TUNE), res_q.left_speed == 8'd0 && res_q.right_speed == 8'd0, "wheels driven while stopped or tuning")
  `LFMC_ASSERT_IMP(a_speed_limits, 1'b1, spd_q[SPD_NORMAL] >= SPD_MIN[SPD_NORMAL] && spd_q[SPD_LOST] >= SPD_MIN[SPD_LOST] && spd_q[SPD_HARD] <= SPD_MAX[SPD_HARD], "speed outside its limits")
  `LFMC_ASSERT_NXT(a_pop_fills_out, pop, out_valid_q, "popped transaction did not reach the output register")

endmodule

### hw/rtl/line_follower_mode_controller_unit.sv
// Top level of the line follower mode controller: ports, configuration registers, wiring.
//
// One transaction per 1 ms tick carries the five line sensors and the button level; one
// result transaction comes back for each. The block takes a new input transaction every
// clock cycle while the queue has room. Each input passes from the gesture classifier
// through a two-entry queue, which the mode machine reads into the output register.
// Input ready drops only while the queue holds two transactions, which happens
// when the output side stalls. Configuration writes (index 0 hold_ticks,
// 1 long_hold_ticks, 2 double_tap_window, 3 center_ticks, 4 turn_timeout_ticks) take
// effect at once; other indexes are ignored. No clearing pass follows reset.
module line_follower_mode_controller_unit import lfmc_pkg::*; #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [4:0] line_sensors, [5] button_down, [7:6] zero
  input  logic [7:0]           s_axis_tdata_i,
  // Output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] left_speed, [15:8] right_speed, [18:16] mode, [21:19] gesture,
  // [23:22] selected_speed, [24] tune_upward, [25] save_pulse, [33:26] normal_speed,
  // [41:34] gentle_turn_speed, [49:42] hard_turn_speed, [57:50] lost_line_speed, [63:58] zero
  output logic [63:0]          m_axis_tdata_o
);

  cfg_t  cfg_q;
  logic  push, q_ready, q_valid, pop;
  item_t push_item, pop_item;
  res_t  res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks         <= CFG_HOLD_RST;
      cfg_q.long_hold_ticks    <= CFG_LONG_HOLD_RST;
      cfg_q.double_tap_window  <= CFG_DBL_WIN_RST;
      cfg_q.center_ticks       <= CFG_CENTER_RST;
      cfg_q.turn_timeout_ticks <= CFG_TURN_TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOLD:      cfg_q.hold_ticks         <= cfg_data_i;
        CFG_LONG_HOLD: cfg_q.long_hold_ticks    <= cfg_data_i;
        CFG_DBL_WIN:   cfg_q.double_tap_window  <= cfg_data_i;
        CFG_CENTER:    cfg_q.center_ticks       <= cfg_data_i;
        CFG_TURN_TMO:  cfg_q.turn_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lfmc_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sensors_i  (s_axis_tdata_i[4:0]),
    .button_i   (s_axis_tdata_i[5]),
    .push_o     (push),
    .item_o     (push_item),
    .q_ready_i  (q_ready)
  );

  lfmc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_item)
  );

  lfmc_back #(
    .TIMER_BITS(TIMER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Result packing, first field lowest
  assign m_axis_tdata_o = {6'b0, res.lost_line_speed, res.hard_turn_speed,
                           res.gentle_turn_speed, res.normal_speed, res.save_pulse,
                           res.tune_upward, res.selected_speed, res.gesture, res.mode,
                           res.right_speed, res.left_speed};

endmodule

### verif/tb_line_follower_mode_controller_unit.sv
// Self-checking testbench for the line follower mode controller: predicted ticks vs results.
`timescale 1ns / 100ps

module tb_line_follower_mode_controller_unit;
  import lfmc_pkg::*;

  localparam int unsigned AGE_W = 12;
  localparam int IDLE_PCT = 29;
  localparam int POST_DRAIN = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRESSURE_AT = 1000;
  localparam int PRESSURE_LEN = 80;
  localparam int CALM_FROM = 1200;
  localparam int CALM_TO = 1500;
  localparam logic [4:0] SENS_NONE = 5'h00;
  localparam logic [4:0] SENS_CENTRE = 5'h04;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // One tick as it travels on the input stream (button above the sensors)
  typedef struct packed {
    logic       button;
    logic [4:0] sensors;
  } tick_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // [4:0] line_sensors, [5] button_down, [7:6] zero
  logic [7:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // [7:0] left, [15:8] right, [18:16] mode, [21:19] gesture, [23:22] selected,
  // [24] upward, [25] save, [33:26] normal, [41:34] gentle, [49:42] hard, [57:50] lost
  logic [63:0] m_axis_tdata_o;

  line_follower_mode_controller_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Controller state as predicted here
  logic [CFG_W-1:0] cfg_hold = CFG_HOLD_RST;
  logic [CFG_W-1:0] cfg_long = CFG_LONG_HOLD_RST;
  logic [CFG_W-1:0] cfg_win = CFG_DBL_WIN_RST;
  logic [CFG_W-1:0] cfg_center = CFG_CENTER_RST;
  logic [CFG_W-1:0] cfg_turn = CFG_TURN_TMO_RST;
  logic [2:0] mode_st = MODE_STOP;
  logic [7:0] spd [4] = SPD_RST;
  logic [1:0] sel_q = SPD_NORMAL;
  logic up_q = 1'b1;
  logic btn_prev = 1'b0;
  logic [AGE_W-1:0] press_age = '0;
  logic [AGE_W-1:0] release_age = '0;
  logic [AGE_W-1:0] inter_age = '0;
  logic [1:0] taps = '0;
  logic tap_wait = 1'b0;

  tick_t tick_q[$];
  res_t result_q[$];
  tick_t cur_tick;
  bit scatter = 1'b0;
  int queued = 0;
  int tx_count = 0;
  int rx_count = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int stall_count = 0;
  int gest_seen [5] = '{default: 0};
  int inter_count = 0;
  int save_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  // Advance the predicted controller by one tick and queue the result it gives
  function automatic void advance_controller(input tick_t t);
    logic [4:0] s;
    logic press_clr, rel_clr, inter_clr, save;
    logic [2:0] ev, md;
    logic [7:0] left, right;
    logic [1:0] k;
    int held, v;
    res_t r;
    s = t.sensors;
    press_clr = 1'b0;
    rel_clr = 1'b0;
    inter_clr = 1'b0;
    save = 1'b0;
    ev = GES_NONE;
    left = '0;
    right = '0;
    md = (mode_st > MODE_TURN) ? MODE_STOP : mode_st;

    // gesture classification from press and release timing
    if (!btn_prev && t.button) begin
      press_age = '0;
      press_clr = 1'b1;
    end else if (btn_prev && !t.button) begin
      held = int'(press_age) + 1;
      if (held >= int'(cfg_long)) begin
        ev = GES_LONG;
        taps = '0;
        tap_wait = 1'b0;
      end else if (held >= int'(cfg_hold)) begin
        ev = GES_HOLD;
        taps = '0;
        tap_wait = 1'b0;
      end else begin
        if (taps < 2'd3) taps = taps + 1'b1;
        release_age = '0;
        rel_clr = 1'b1;
        tap_wait = 1'b1;
      end
    end
    if (tap_wait && !rel_clr && release_age >= cfg_win) begin
      ev = (taps >= 2'd2) ? GES_DOUBLE : GES_SINGLE;
      taps = '0;
      tap_wait = 1'b0;
    end
    btn_prev = t.button;

    // mode changes on gestures
    case (md)
      MODE_STOP: begin
        if (ev == GES_SINGLE) md = MODE_RUN;
        else if (ev == GES_HOLD) begin
          md = MODE_TUNE;
          sel_q = SPD_NORMAL;
          up_q = 1'b1;
        end
      end
      MODE_TUNE: begin
        k = sel_q;
        if (ev == GES_SINGLE) begin
          v = int'(spd[k]) + (up_q ? int'(SPEED_STEP) : -int'(SPEED_STEP));
          if (v < int'(SPD_MIN[k])) v = int'(SPD_MIN[k]);
          if (v > int'(SPD_MAX[k])) v = int'(SPD_MAX[k]);
          spd[k] = v[7:0];
        end else if (ev == GES_DOUBLE) begin
          up_q = ~up_q;
        end else if (ev == GES_HOLD) begin
          sel_q = k + 1'b1;
        end else if (ev == GES_LONG) begin
          save = 1'b1;
          md = MODE_STOP;
        end
      end
      default: begin
        if (ev == GES_SINGLE) md = MODE_STOP;
        else if (ev == GES_HOLD) begin
          md = MODE_TUNE;
          sel_q = SPD_NORMAL;
          up_q = 1'b1;
        end
      end
    endcase

    // wheel drive
    case (md)
      MODE_RUN: begin
        if (s == SENS_ALL) begin
          md = MODE_FWD;
          inter_age = '0;
          inter_clr = 1'b1;
          inter_count++;
          left = spd[SPD_NORMAL];
          right = spd[SPD_NORMAL];
        end else if (s == SENS_NONE) begin
          left = spd[SPD_LOST];
          right = spd[SPD_LOST];
        end else if (s[4]) begin
          left = spd[SPD_NORMAL];
          right = spd[SPD_HARD];
        end else if (s[3]) begin
          left = spd[SPD_NORMAL];
          right = spd[SPD_GENTLE];
        end else if (s[2] && !s[1]) begin
          left = spd[SPD_NORMAL];
          right = spd[SPD_NORMAL];
        end else if (s[1] && !s[0]) begin
          left = spd[SPD_GENTLE];
          right = spd[SPD_NORMAL];
        end else if (s[0]) begin
          left = spd[SPD_HARD];
          right = spd[SPD_NORMAL];
        end else begin
          left = spd[SPD_NORMAL];
          right = spd[SPD_NORMAL];
        end
      end
      MODE_FWD: begin
        left = spd[SPD_NORMAL];
        right = spd[SPD_NORMAL];
        if (int'(inter_age) + 1 >= int'(cfg_center)) begin
          md = MODE_TURN;
          inter_age = '0;
          inter_clr = 1'b1;
        end
      end
      MODE_TURN: begin
        left = spd[SPD_NORMAL];
        if (s[2] || int'(inter_age) + 1 >= int'(cfg_turn)) md = MODE_RUN;
      end
      default: ;
    endcase
    mode_st = md;

    if (!press_clr) press_age = sat_inc(press_age);
    if (!rel_clr) release_age = sat_inc(release_age);
    if (!inter_clr) inter_age = sat_inc(inter_age);

    r.left_speed = left;
    r.right_speed = right;
    r.mode = md;
    r.gesture = ev;
    r.selected_speed = sel_q;
    r.tune_upward = up_q;
    r.save_pulse = save;
    r.normal_speed = spd[SPD_NORMAL];
    r.gentle_turn_speed = spd[SPD_GENTLE];
    r.hard_turn_speed = spd[SPD_HARD];
    r.lost_line_speed = spd[SPD_LOST];
    result_q.push_back(r);
    gest_seen[ev]++;
    if (save) save_count++;
  endfunction

  function automatic res_t unpack_result(input logic [63:0] d);
    res_t r;
    r.left_speed = d[7:0];
    r.right_speed = d[15:8];
    r.mode = d[18:16];
    r.gesture = d[21:19];
    r.selected_speed = d[23:22];
    r.tune_upward = d[24];
    r.save_pulse = d[25];
    r.normal_speed = d[33:26];
    r.gentle_turn_speed = d[41:34];
    r.hard_turn_speed = d[49:42];
    r.lost_line_speed = d[57:50];
    return r;
  endfunction

  function automatic string field_diff(input res_t e, input res_t a);
    string d;
    d = "";
    if (e.left_speed !== a.left_speed) d = {d, " left_speed"};
    if (e.right_speed !== a.right_speed) d = {d, " right_speed"};
    if (e.mode !== a.mode) d = {d, " mode"};
    if (e.gesture !== a.gesture) d = {d, " gesture"};
    if (e.selected_speed !== a.selected_speed) d = {d, " selected_speed"};
    if (e.tune_upward !== a.tune_upward) d = {d, " tune_upward"};
    if (e.save_pulse !== a.save_pulse) d = {d, " save_pulse"};
    if (e.normal_speed !== a.normal_speed) d = {d, " normal_speed"};
    if (e.gentle_turn_speed !== a.gentle_turn_speed) d = {d, " gentle_turn_speed"};
    if (e.hard_turn_speed !== a.hard_turn_speed) d = {d, " hard_turn_speed"};
    if (e.lost_line_speed !== a.lost_line_speed) d = {d, " lost_line_speed"};
    return d;
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Tick driver: launches queued ticks, predicts each accepted one
  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    bit calm;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        advance_controller(cur_tick);
        tx_count++;
      end
      calm = (tx_count >= CALM_FROM) && (tx_count < CALM_TO);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_tick = tick_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {2'b00, cur_tick};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result transaction, drives backpressure
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    res_t got, want;
    string diff;
    bit calm;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = unpack_result(m_axis_tdata_o);
        rx_count++;
        if (result_q.size() == 0) begin
          log_failure($sformatf("result %0d arrived with nothing expected: %p", rx_count, got));
        end else begin
          want = result_q.pop_front();
          diff = field_diff(want, got);
          if (diff != "")
            log_failure($sformatf("result %0d: mismatch in%s; expected %p, got %p",
                                  rx_count, diff, want, got));
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (s_axis_tvalid_i && !s_axis_tready_o) stall_count++;

      // one long hold-off so the block fills up, otherwise random stalls outside the calm stretch
      calm = (rx_count >= CALM_FROM) && (rx_count < CALM_TO);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!pressure_done && rx_count >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_LEN;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    wait (rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("** line_follower_mode_controller_unit: FAILED **");
    $finish;
  end

  function automatic logic [4:0] pick_sensors();
    int r;
    r = $urandom_range(99);
    if (r < 15) return SENS_ALL;
    if (r < 25) return SENS_NONE;
    if (r < 55) return 5'(1 << $urandom_range(4));
    return 5'($urandom_range(31));
  endfunction

  task automatic add_tick(input logic btn, input logic [4:0] s);
    tick_t t;
    t.button = btn;
    t.sensors = scatter ? pick_sensors() : s;
    tick_q.push_back(t);
    queued++;
  endtask

  // n ticks pressed, then the release tick
  task automatic press(input int n, input logic [4:0] s);
    repeat (n) add_tick(1'b1, s);
    add_tick(1'b0, s);
  endtask

  task automatic idle(input int n, input logic [4:0] s);
    repeat (n) add_tick(1'b0, s);
  endtask

  task automatic single_tap(input logic [4:0] s);
    press(1, s);
    idle(int'(cfg_win) + 1, s);
  endtask

  task automatic double_tap(input logic [4:0] s);
    press(1, s);
    press(1, s);
    idle(int'(cfg_win) + 1, s);
  endtask

  // Everything sent has come back, plus the pipeline latency
  task automatic wait_idle();
    while (tx_count != queued || result_q.size() != 0) @(posedge clk_i);
    repeat (POST_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_HOLD: cfg_hold = val;
      CFG_LONG_HOLD: cfg_long = val;
      CFG_DBL_WIN: cfg_win = val;
      CFG_CENTER: cfg_center = val;
      CFG_TURN_TMO: cfg_turn = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] l,
                            input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] c,
                            input logic [CFG_W-1:0] t);
    wait_idle();
    write_reg(CFG_HOLD, h);
    write_reg(CFG_LONG_HOLD, l);
    write_reg(CFG_DBL_WIN, w);
    write_reg(CFG_CENTER, c);
    write_reg(CFG_TURN_TMO, t);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random gesture shaped around the current thresholds
  task automatic random_gesture();
    int r, hmin, lmin, w;
    hmin = (cfg_hold == 0) ? 1 : int'(cfg_hold);
    lmin = (cfg_long == 0) ? 1 : int'(cfg_long);
    w = int'(cfg_win);
    r = $urandom_range(99);
    if (r < 40) begin
      press($urandom_range(1, (hmin > 1) ? hmin - 1 : 1), SENS_NONE);
      idle($urandom_range(1, w + 3), SENS_NONE);
    end else if (r < 55) begin
      repeat ($urandom_range(2, 3)) begin
        press($urandom_range(1, (hmin > 1) ? hmin - 1 : 1), SENS_NONE);
        idle($urandom_range(0, w), SENS_NONE);
      end
      idle(w + 2, SENS_NONE);
    end else if (r < 70) begin
      press($urandom_range(hmin, (lmin - 1 > hmin) ? lmin - 1 : hmin), SENS_NONE);
      idle($urandom_range(0, 3), SENS_NONE);
    end else if (r < 78) begin
      press($urandom_range(lmin, lmin + 3), SENS_NONE);
      idle($urandom_range(0, 3), SENS_NONE);
    end else if (r < 94) begin
      idle($urandom_range(1, w + 8), SENS_NONE);
    end else begin
      repeat ($urandom_range(1, 6)) add_tick(1'($urandom_range(1)), SENS_NONE);
    end
  endtask

  initial begin : stimulus
    int start, h;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset timing: a tap decided only after the default window
    scatter = 1'b1;
    press(1, SENS_NONE);
    idle(402, SENS_NONE);

    // Directed part with short timing
    scatter = 1'b0;
    set_timing(12'd4, 12'd8, 12'd2, 12'd2, 12'd3);
    write_reg(CFG_UNUSED, 12'hABC);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (mode_st == MODE_TUNE) press(9, SENS_CENTRE);
    else if (mode_st != MODE_STOP) single_tap(SENS_CENTRE);
    add_tick(1'b0, SENS_NONE);
    add_tick(1'b0, SENS_ALL);
    single_tap(SENS_CENTRE);
    add_tick(1'b0, 5'h00);
    add_tick(1'b0, 5'h10);
    add_tick(1'b0, 5'h08);
    add_tick(1'b0, 5'h04);
    add_tick(1'b0, 5'h06);
    add_tick(1'b0, 5'h02);
    add_tick(1'b0, 5'h03);
    add_tick(1'b0, 5'h01);
    add_tick(1'b0, 5'h05);
    add_tick(1'b0, 5'h07);
    // intersection ending on the turn timeout, then one ending on the centre sensor
    add_tick(1'b0, SENS_ALL);
    idle(6, SENS_NONE);
    add_tick(1'b0, SENS_ALL);
    idle(2, SENS_NONE);
    add_tick(1'b0, SENS_CENTRE);
    // three quick taps saturate into a double; a hold drops a pending tap
    press(1, SENS_CENTRE);
    press(1, SENS_CENTRE);
    press(1, SENS_CENTRE);
    idle(3, SENS_CENTRE);
    press(1, SENS_CENTRE);
    press(5, SENS_CENTRE);

    // Tuning sweep: every speed driven into its clamp, selection wraps
    single_tap(SENS_CENTRE);
    double_tap(SENS_CENTRE);
    repeat (22) single_tap(SENS_CENTRE);
    press(5, SENS_CENTRE);
    repeat (16) single_tap(SENS_CENTRE);
    press(5, SENS_CENTRE);
    double_tap(SENS_CENTRE);
    repeat (11) single_tap(SENS_CENTRE);
    press(5, SENS_CENTRE);
    repeat (6) single_tap(SENS_CENTRE);
    press(5, SENS_CENTRE);
    press(9, SENS_CENTRE);

    // Random gestures over several timing settings, extremes first
    scatter = 1'b1;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_timing(12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
        1: set_timing(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        2: set_timing(12'd3, 12'd6, 12'd0, 12'd0, 12'd0);
        default: begin
          h = $urandom_range(2, 10);
          set_timing(CFG_W'(h), CFG_W'($urandom_range(1, h + 12)),
                     CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 8)),
                     CFG_W'($urandom_range(1, 16)));
        end
      endcase
      start = queued;
      while (queued - start < ((p < 2) ? 60 : 160)) random_gesture();
    end

    wait_idle();
    $display("%0d ticks checked; gestures single/double/hold/long: %0d/%0d/%0d/%0d",
             rx_count, gest_seen[GES_SINGLE], gest_seen[GES_DOUBLE], gest_seen[GES_HOLD],
             gest_seen[GES_LONG]);
    $display("%0d intersections, %0d save pulses, %0d input stall cycles, %0d mismatches",
             inter_count, save_count, stall_count, fail_count);
    if (fail_count == 0) begin
      $display("** line_follower_mode_controller_unit: PASSED **");
    end else begin
      $display("** line_follower_mode_controller_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lfmc_pkg.sv
hw/rtl/lfmc_front.sv
hw/rtl/lfmc_queue.sv
hw/rtl/lfmc_back.sv
hw/rtl/line_follower_mode_controller_unit.sv
verif/tb_line_follower_mode_controller_unit.sv
